/* hw/rtl/stpd_pkg.sv */
// shared types, opcode codes and constants of the stack opcode unit
`timescale 1ns / 1ps
`default_nettype none
package stpd_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = 11;
    localparam int GAS_W       = 64;
    localparam int WORD_W      = 256;
    localparam int CNT_W       = 6;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(STACK_DEPTH);
    localparam logic [GAS_W-1:0]   GAS_BASE    = GAS_W'(2);
    localparam logic [GAS_W-1:0]   GAS_VERYLOW = GAS_W'(3);

    localparam logic [7:0] OP_POP    = 8'h50;
    localparam logic [7:0] OP_PUSH0  = 8'h5f;
    localparam logic [7:0] OP_PUSH32 = 8'h7f;
    localparam logic [7:0] OP_DUP1   = 8'h80;
    localparam logic [7:0] OP_DUP16  = 8'h8f;
    localparam logic [7:0] OP_SWAP1  = 8'h90;
    localparam logic [7:0] OP_SWAP16 = 8'h9f;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDER     = 3'd1;
    localparam logic [2:0] ST_OVER      = 3'd2;
    localparam logic [2:0] ST_OOG       = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;
    localparam logic [2:0] ST_UNHANDLED = 3'd5;
    localparam logic [2:0] ST_HALTED    = 3'd6;

    localparam logic CFG_START_GAS = 1'b0;
    localparam logic CFG_PUSH0_EN  = 1'b1;

    typedef enum logic [2:0] {
        K_RESTART,
        K_POP,
        K_PUSH,
        K_DUP,
        K_SWAP,
        K_OTHER
    } t_kind;

    typedef struct packed {
        logic        restart;
        logic [7:0]  opcode;
        logic [63:0] imm_word3;
        logic [63:0] imm_word2;
        logic [63:0] imm_word1;
        logic [63:0] imm_word0;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] gas_left;
        logic [10:0] depth_now;
        logic [63:0] top_word3;
        logic [63:0] top_word2;
        logic [63:0] top_word1;
        logic [63:0] top_word0;
    } t_out_item;

    typedef struct packed {
        t_kind              kind;
        logic [CNT_W-1:0]   cnt;
        logic [WORD_W-1:0]  imm;
    } t_cmd;

endpackage
`default_nettype wire

/* hw/rtl/stack_push_dup_swap_unit.sv */
// top level of the stack opcode unit
// Executes POP, PUSH0..PUSH32, DUP1..16 and SWAP1..16 on a 1024-entry stack of
// 256-bit words with a 64-bit gas counter, one result transaction per input
// transaction. A two-entry command queue sits after opcode decode; the
// execute stage then completes restart, PUSH, DUP1, faults, unhandled
// opcodes and halted items from its idle state, while POP, DUP2..16 and
// SWAP pass through a wait state for the registered read of the
// single-read-port stack memory. The top of stack is held in a register, so
// each item writes the memory at most once. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
module stack_push_dup_swap_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_idx,
    input  wire [63:0]          i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  stpd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output stpd_pkg::t_out_item o_out_data
);

    logic           cmd_valid, cmd_take;
    stpd_pkg::t_cmd cmd;

    stpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take),
        .o_cmd       (cmd)
    );

    stpd_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

/* hw/rtl/stpd_front.sv */
// front end: opcode classification, immediate trimming and command queue
`timescale 1ns / 1ps
`default_nettype none
module stpd_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  stpd_pkg::t_in_item  i_in_data,
    output logic                o_cmd_valid,
    input  wire                 i_cmd_take,
    output stpd_pkg::t_cmd      o_cmd
);

    stpd_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    stpd_pkg::t_cmd n_cmd;
    logic [stpd_pkg::WORD_W-1:0] raw;
    logic [7:0]     op;
    logic           push_q, pop_q;

    always_comb begin
        op  = i_in_data.opcode;
        raw = {i_in_data.imm_word3, i_in_data.imm_word2,
               i_in_data.imm_word1, i_in_data.imm_word0};
        n_cmd.cnt  = '0;
        n_cmd.kind = stpd_pkg::K_OTHER;
        if (i_in_data.restart) begin
            n_cmd.kind = stpd_pkg::K_RESTART;
        end else if (op == stpd_pkg::OP_POP) begin
            n_cmd.kind = stpd_pkg::K_POP;
        end else if (op inside {[stpd_pkg::OP_PUSH0:stpd_pkg::OP_PUSH32]}) begin
            n_cmd.kind = stpd_pkg::K_PUSH;
            n_cmd.cnt  = stpd_pkg::CNT_W'(op - stpd_pkg::OP_PUSH0);
        end else if (op inside {[stpd_pkg::OP_DUP1:stpd_pkg::OP_DUP16]}) begin
            n_cmd.kind = stpd_pkg::K_DUP;
            n_cmd.cnt  = stpd_pkg::CNT_W'(op - stpd_pkg::OP_PUSH32);
        end else if (op inside {[stpd_pkg::OP_SWAP1:stpd_pkg::OP_SWAP16]}) begin
            n_cmd.kind = stpd_pkg::K_SWAP;
            n_cmd.cnt  = stpd_pkg::CNT_W'(op - stpd_pkg::OP_DUP16);
        end
        // keep only the low cnt bytes of the immediate
        for (int b = 0; b < stpd_pkg::WORD_W / 8; b++) begin
            n_cmd.imm[b*8 +: 8] = (b < int'(n_cmd.cnt)) ? raw[b*8 +: 8] : 8'h00;
        end
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push_q      = i_in_valid && !o_in_stall;
    assign pop_q       = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push_q) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_q) begin
                r_wp <= ~r_wp;
            end
            if (pop_q) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push_q) - 2'(pop_q);
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/stpd_exec.sv */
// back end: stack memory, height, gas, halt and result register
`timescale 1ns / 1ps
`default_nettype none
module stpd_exec (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_idx,
    input  wire [63:0]          i_cfg_data,
    input  wire                 i_cmd_valid,
    output logic                o_cmd_take,
    input  stpd_pkg::t_cmd      i_cmd,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output stpd_pkg::t_out_item o_out_data
);

    typedef enum logic {S_IDLE, S_WAIT} t_state;

    localparam int AW = stpd_pkg::ADDR_W;
    localparam int DW = stpd_pkg::DEPTH_W;
    localparam int GW = stpd_pkg::GAS_W;
    localparam int WW = stpd_pkg::WORD_W;

    logic [WW-1:0] r_mem [stpd_pkg::STACK_DEPTH];
    logic [WW-1:0] r_rd;

    t_state        r_state, n_state;
    logic [DW-1:0] r_h, n_h;
    logic [GW-1:0] r_gas, n_gas;
    logic          r_halt, n_halt;
    logic [WW-1:0] r_top, n_top;
    logic [AW-1:0] r_wa, n_wa;
    logic          r_wpend, n_wpend;
    logic [GW-1:0] r_start_gas;
    logic          r_p0_en;
    logic          r_ov;
    stpd_pkg::t_out_item r_out;

    logic          out_free, out_load;
    logic [2:0]    out_st;
    logic [WW-1:0] out_top;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic          fault;
    logic [2:0]    fault_st;
    logic [DW-1:0] n_ext;
    logic [GW-1:0] cost;

    assign out_free = !r_ov || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_h      = r_h;
        n_gas    = r_gas;
        n_halt   = r_halt;
        n_top    = r_top;
        n_wa     = r_wa;
        n_wpend  = r_wpend;
        o_cmd_take = 1'b0;
        out_load = 1'b0;
        out_st   = stpd_pkg::ST_OK;
        mem_we   = 1'b0;
        mem_wa   = AW'(r_h - DW'(1));
        mem_re   = 1'b0;
        mem_ra   = '0;
        fault    = 1'b0;
        fault_st = stpd_pkg::ST_OK;
        n_ext    = DW'(i_cmd.cnt);
        cost     = (i_cmd.cnt == '0) ? stpd_pkg::GAS_BASE : stpd_pkg::GAS_VERYLOW;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_take = 1'b1;
                    out_load   = 1'b1;
                    if (i_cmd.kind == stpd_pkg::K_RESTART) begin
                        n_h    = '0;
                        n_gas  = r_start_gas;
                        n_halt = 1'b0;
                    end else if (r_halt) begin
                        out_st = stpd_pkg::ST_HALTED;
                    end else begin
                        case (i_cmd.kind)
                            stpd_pkg::K_POP: begin
                                if (r_h == '0) begin
                                    fault = 1'b1; fault_st = stpd_pkg::ST_UNDER;
                                end else if (r_gas < stpd_pkg::GAS_BASE) begin
                                    fault = 1'b1; fault_st = stpd_pkg::ST_OOG;
                                end else begin
                                    n_gas    = r_gas - stpd_pkg::GAS_BASE;
                                    n_h      = r_h - DW'(1);
                                    mem_re   = 1'b1;
                                    mem_ra   = AW'(r_h - DW'(2));
                                    n_wpend  = 1'b0;
                                    n_state  = S_WAIT;
                                    out_load = 1'b0;
                                end
                            end
                            stpd_pkg::K_PUSH: begin
                                if (i_cmd.cnt == '0 && !r_p0_en) begin
                                    fault = 1'b1; fault_st = stpd_pkg::ST_INVALID;
                                end else if (r_h >= stpd_pkg::DEPTH_MAX) begin
                                    fault = 1'b1; fault_st = stpd_pkg::ST_OVER;
                                end else if (r_gas < cost) begin
                                    fault = 1'b1; fault_st = stpd_pkg::ST_OOG;
                                end else begin
                                    n_gas  = r_gas - cost;
                                    n_h    = r_h + DW'(1);
                                    mem_we = (r_h != '0);
                                    n_top  = i_cmd.imm;
                                end
                            end
                            stpd_pkg::K_DUP: begin
                                if (r_h < n_ext) begin
                                    fault = 1'b1; fault_st = stpd_pkg::ST_UNDER;
                                end else if (r_h >= stpd_pkg::DEPTH_MAX) begin
                                    fault = 1'b1; fault_st = stpd_pkg::ST_OVER;
                                end else if (r_gas < stpd_pkg::GAS_VERYLOW) begin
                                    fault = 1'b1; fault_st = stpd_pkg::ST_OOG;
                                end else begin
                                    n_gas = r_gas - stpd_pkg::GAS_VERYLOW;
                                    n_h   = r_h + DW'(1);
                                    if (i_cmd.cnt == stpd_pkg::CNT_W'(1)) begin
                                        mem_we = 1'b1;
                                    end else begin
                                        mem_re   = 1'b1;
                                        mem_ra   = AW'(r_h - n_ext);
                                        n_wa     = AW'(r_h - DW'(1));
                                        n_wpend  = 1'b1;
                                        n_state  = S_WAIT;
                                        out_load = 1'b0;
                                    end
                                end
                            end
                            stpd_pkg::K_SWAP: begin
                                if (r_h <= n_ext) begin
                                    fault = 1'b1; fault_st = stpd_pkg::ST_UNDER;
                                end else if (r_gas < stpd_pkg::GAS_VERYLOW) begin
                                    fault = 1'b1; fault_st = stpd_pkg::ST_OOG;
                                end else begin
                                    n_gas    = r_gas - stpd_pkg::GAS_VERYLOW;
                                    mem_re   = 1'b1;
                                    mem_ra   = AW'(r_h - DW'(1) - n_ext);
                                    n_wa     = AW'(r_h - DW'(1) - n_ext);
                                    n_wpend  = 1'b1;
                                    n_state  = S_WAIT;
                                    out_load = 1'b0;
                                end
                            end
                            default: begin
                                out_st = stpd_pkg::ST_UNHANDLED;
                            end
                        endcase
                        if (fault) begin
                            n_gas  = '0;
                            n_halt = 1'b1;
                            out_st = fault_st;
                        end
                    end
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    mem_we   = r_wpend;
                    mem_wa   = r_wa;
                    n_top    = r_rd;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        out_top = (n_h == '0) ? '0 : n_top;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= r_top;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_wa  <= n_wa;
        if (out_load) begin
            r_out.status    <= out_st;
            r_out.gas_left  <= n_gas;
            r_out.depth_now <= n_h;
            r_out.top_word0 <= out_top[63:0];
            r_out.top_word1 <= out_top[127:64];
            r_out.top_word2 <= out_top[191:128];
            r_out.top_word3 <= out_top[255:192];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_h         <= '0;
            r_gas       <= '0;
            r_halt      <= 1'b0;
            r_wpend     <= 1'b0;
            r_ov        <= 1'b0;
            r_start_gas <= '0;
            r_p0_en     <= 1'b1;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            r_gas   <= n_gas;
            r_halt  <= n_halt;
            r_wpend <= n_wpend;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    stpd_pkg::CFG_START_GAS: r_start_gas <= i_cfg_data;
                    stpd_pkg::CFG_PUSH0_EN:  r_p0_en     <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

/* hw/rtl/stpd_checker.sv */
// port-level checks of the stack opcode unit and their bind
`timescale 1ns / 1ps
`default_nettype none
module stpd_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input stpd_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped while stalled");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.depth_now <= stpd_pkg::DEPTH_MAX)
        else $error("depth beyond limit");

    a_fault_gas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == stpd_pkg::ST_UNDER
            || o_out_data.status == stpd_pkg::ST_OVER
            || o_out_data.status == stpd_pkg::ST_OOG
            || o_out_data.status == stpd_pkg::ST_INVALID)
        |-> o_out_data.gas_left == '0)
        else $error("fault left gas");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.depth_now == '0
        |-> o_out_data.top_word0 == '0 && o_out_data.top_word1 == '0
            && o_out_data.top_word2 == '0 && o_out_data.top_word3 == '0)
        else $error("empty stack shows a top word");

endmodule

bind stack_push_dup_swap_unit stpd_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire
